/* rtl/core/dss_pkg.sv */
`default_nettype none

package dss_pkg;

   localparam int MAX_DELIM_LEN_DEF = 8;
   localparam int BYTE_W            = 8;
   localparam int DELIM_W           = 64;
   localparam int LEN_W             = 4;
   localparam int CSR_IDX_W         = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_PIECE_END = 2'd1,
      KIND_INPUT_END = 2'd2
   } dss_kind_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_CLOSE,
      ST_DONE
   } dss_state_type;

   typedef struct packed {
      logic en;
      logic shift;
   } dss_cell_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/dss_cell.sv */
`default_nettype none

module dss_cell (
   input  wire                             clock,
   input  wire dss_pkg::dss_cell_ctl_type  ctl,
   input  wire                             wr,
   input  wire [dss_pkg::BYTE_W-1:0]       data_in,
   input  wire [dss_pkg::BYTE_W-1:0]       right_after,
   input  wire [dss_pkg::BYTE_W-1:0]       delim,
   input  wire                             in_use,
   output logic [dss_pkg::BYTE_W-1:0]      after,
   output logic                            match_ok
);

   logic [dss_pkg::BYTE_W-1:0] byte_ff;
   logic [dss_pkg::BYTE_W-1:0] byte_in;

   always_comb begin
      after    = wr ? data_in : byte_ff;
      match_ok = !in_use || (after == delim);
      byte_in  = ctl.shift ? right_after : after;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/delimiter_stream_splitter_top.sv */
`default_nettype none

// Channel  Dir  Handshake                  Payload
// req      in   req_tvalid / req_tready    tdata: data_byte, tlast: final_byte
// rsp      out  rsp_tvalid / rsp_tready    tdata: piece_byte, tuser: item_kind,
//                                          tlast: last_of_run
// csr      in   csr_valid / csr_ready      csr_index, csr_data
//
// One byte per cycle while rsp is not stalled; a byte completing the window has
// its result registered as the next byte is taken. The final byte leaves the cell
// row shifting out one byte per cycle unless rsp stalls, then end of piece (if
// open) and end of input follow; input shorter than the delimiter gives end of
// input only. Synchronous reset clears fill, flags, state, delimiter and length,
// not window bytes. A stalled rsp holds the output register and blocks req.

module delimiter_stream_splitter_top #(
   parameter int MAX_DELIM_LEN = dss_pkg::MAX_DELIM_LEN_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [7:0]                         req_tdata,   // [7:0] data_byte
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] piece_byte
   output logic [1:0]                         rsp_tuser,   // [1:0] item_kind
   output logic                               rsp_tlast,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [dss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [dss_pkg::DELIM_W-1:0]        csr_data
);

   localparam int FILL_W = $clog2(MAX_DELIM_LEN + 1);
   localparam int BW     = dss_pkg::BYTE_W;

   logic [dss_pkg::DELIM_W-1:0] delim_ff, delim_in;
   logic [dss_pkg::LEN_W-1:0]   len_raw_ff, len_raw_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [FILL_W-1:0]           seen_ff, seen_in;
   logic                        open_ff, open_in;
   dss_pkg::dss_state_type      state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dss_pkg::dss_kind_type       rsp_kind_ff;
   logic [BW-1:0]               rsp_byte_ff;
   logic                        rsp_last_ff;

   logic [FILL_W-1:0]           len_eff;
   logic                        load_ok;
   logic                        req_accept;
   logic                        csr_accept;
   logic                        len_write;
   logic [FILL_W-1:0]           wpos;
   logic                        full;
   logic                        match;
   logic [MAX_DELIM_LEN-1:0]    match_vec;
   logic [BW-1:0]               after [MAX_DELIM_LEN];
   logic [BW-1:0]               right [MAX_DELIM_LEN];
   logic [MAX_DELIM_LEN-1:0]    wr_vec;
   logic [MAX_DELIM_LEN-1:0]    use_vec;
   dss_pkg::dss_cell_ctl_type   cell_ctl;

   logic                        step_emit;
   dss_pkg::dss_kind_type       step_kind;
   logic [BW-1:0]               step_byte;
   logic [FILL_W-1:0]           step_fill;
   logic                        step_open;
   logic                        step_shift;
   logic [FILL_W-1:0]           seen_next;
   logic                        seen_ok;

   logic                        emit;
   dss_pkg::dss_kind_type       emit_kind;
   logic [BW-1:0]               emit_byte;
   logic                        emit_last;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign len_write  = csr_accept && (csr_index == dss_pkg::CSR_DELIM_LENGTH);
   assign load_ok    = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dss_pkg::ST_RUN) && load_ok;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (len_raw_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if (len_raw_ff > dss_pkg::LEN_W'(MAX_DELIM_LEN)) begin
         len_eff = FILL_W'(MAX_DELIM_LEN);
      end else begin
         len_eff = FILL_W'(len_raw_ff);
      end
   end

   always_comb begin
      delim_in   = delim_ff;
      len_raw_in = len_raw_ff;
      if (csr_accept && (csr_index == dss_pkg::CSR_DELIM_BYTES)) begin
         delim_in = csr_data;
      end
      if (len_write) begin
         len_raw_in = csr_data[dss_pkg::LEN_W-1:0];
      end
   end

   assign wpos = (fill_ff >= len_eff) ? '0 : fill_ff;
   assign full = ((wpos + FILL_W'(1)) == len_eff);

   genvar k;
   generate
      for (k = 0; k < MAX_DELIM_LEN; k++) begin : g_cell
         assign wr_vec[k]  = req_accept && (wpos == FILL_W'(k));
         assign use_vec[k] = FILL_W'(k) < len_eff;
         if (k == MAX_DELIM_LEN - 1) begin : g_end
            assign right[k] = '0;
         end else begin : g_mid
            assign right[k] = after[k+1];
         end
         dss_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl),
            .wr          (wr_vec[k]),
            .data_in     (req_tdata),
            .right_after (right[k]),
            .delim       (delim_ff[BW*k +: BW]),
            .in_use      (use_vec[k]),
            .after       (after[k]),
            .match_ok    (match_vec[k])
         );
      end
   endgenerate

   assign match = &match_vec;

   always_comb begin
      step_emit  = 1'b0;
      step_kind  = dss_pkg::KIND_DATA;
      step_byte  = after[0];
      step_fill  = wpos + FILL_W'(1);
      step_open  = open_ff;
      step_shift = 1'b0;
      if (full) begin
         if (match) begin
            step_emit = open_ff;
            step_kind = dss_pkg::KIND_PIECE_END;
            step_byte = '0;
            step_fill = '0;
            step_open = 1'b0;
         end else begin
            step_emit  = 1'b1;
            step_open  = 1'b1;
            step_fill  = len_eff - FILL_W'(1);
            step_shift = 1'b1;
         end
      end
   end

   assign seen_next = (seen_ff < len_eff) ? seen_ff + FILL_W'(1) : seen_ff;
   assign seen_ok   = (seen_next >= len_eff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dss_pkg::ST_RUN: begin
            if (req_accept && req_tlast) begin
               if (!seen_ok) begin
                  state_in = dss_pkg::ST_DONE;
               end else if (step_fill != '0) begin
                  state_in = dss_pkg::ST_FLUSH;
               end else if (step_open) begin
                  state_in = dss_pkg::ST_CLOSE;
               end else begin
                  state_in = dss_pkg::ST_DONE;
               end
            end
         end
         dss_pkg::ST_FLUSH: begin
            if (load_ok && (fill_ff == FILL_W'(1))) begin
               state_in = dss_pkg::ST_CLOSE;
            end
         end
         dss_pkg::ST_CLOSE: begin
            if (load_ok) begin
               state_in = dss_pkg::ST_DONE;
            end
         end
         dss_pkg::ST_DONE: begin
            if (load_ok) begin
               state_in = dss_pkg::ST_RUN;
            end
         end
         default: state_in = dss_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      emit         = 1'b0;
      emit_kind    = dss_pkg::KIND_DATA;
      emit_byte    = '0;
      emit_last    = 1'b0;
      cell_ctl.en    = 1'b0;
      cell_ctl.shift = 1'b0;
      unique case (state_ff)
         dss_pkg::ST_RUN: begin
            emit           = req_accept && step_emit;
            emit_kind      = step_kind;
            emit_byte      = step_byte;
            emit_last      = !req_tlast;
            cell_ctl.en    = req_accept;
            cell_ctl.shift = step_shift;
         end
         dss_pkg::ST_FLUSH: begin
            emit           = load_ok;
            emit_kind      = dss_pkg::KIND_DATA;
            emit_byte      = after[0];
            cell_ctl.en    = load_ok;
            cell_ctl.shift = 1'b1;
         end
         dss_pkg::ST_CLOSE: begin
            emit      = load_ok;
            emit_kind = dss_pkg::KIND_PIECE_END;
         end
         dss_pkg::ST_DONE: begin
            emit      = load_ok;
            emit_kind = dss_pkg::KIND_INPUT_END;
            emit_last = 1'b1;
         end
         default: emit = 1'b0;
      endcase
   end

   assign rsp_valid_in = load_ok ? emit : rsp_valid_ff;

   always_comb begin
      fill_in = fill_ff;
      open_in = open_ff;
      seen_in = seen_ff;
      priority if (len_write) begin
         fill_in = '0;
         open_in = 1'b0;
         seen_in = '0;
      end else if (req_accept) begin
         if (req_tlast) begin
            fill_in = seen_ok ? step_fill : '0;
            open_in = 1'b0;
            seen_in = '0;
         end else begin
            fill_in = step_fill;
            open_in = step_open;
            seen_in = seen_next;
         end
      end else if ((state_ff == dss_pkg::ST_FLUSH) && load_ok) begin
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= '0;
         len_raw_ff   <= dss_pkg::LEN_W'(1);
         fill_ff      <= '0;
         open_ff      <= 1'b0;
         seen_ff      <= '0;
         state_ff     <= dss_pkg::ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         delim_ff     <= delim_in;
         len_raw_ff   <= len_raw_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         seen_ff      <= seen_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
      end
   end

   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dss_pkg::ST_RUN) |-> (fill_ff < len_eff))
      else $error("window fill reached delimiter length");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dss_pkg::ST_FLUSH) |-> (fill_ff != '0))
      else $error("flush entered with empty window");

   a_final_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("request taken right after final byte");

   a_input_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == dss_pkg::KIND_INPUT_END)) |-> rsp_last_ff)
      else $error("end of input not marked last");

endmodule

`default_nettype wire

/* verif/delimiter_stream_splitter_top_tb.sv */
`default_nettype none

module delimiter_stream_splitter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 340;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 120;
   localparam int PRESSURE_BYTES = 60;

   typedef struct packed {
      dss_pkg::dss_kind_type        kind;
      logic [dss_pkg::BYTE_W-1:0]   data;
      logic                         last;
   } split_result_type;

   typedef struct packed {
      logic                          is_csr;
      logic [dss_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [dss_pkg::DELIM_W-1:0]   csr_value;
      logic [dss_pkg::BYTE_W-1:0]    data;
      logic                          fin;
      logic                          known;
      logic                          known_count;
      split_result_type              known_res;
   } stim_row_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = '0;
   logic                          req_tlast  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [dss_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [dss_pkg::DELIM_W-1:0]   csr_data   = '0;

   // predictor state
   logic [dss_pkg::DELIM_W-1:0]   delim_pattern;
   logic [dss_pkg::LEN_W-1:0]     delim_len_code;
   logic [dss_pkg::BYTE_W-1:0]    win_bytes [dss_pkg::MAX_DELIM_LEN_DEF];
   int unsigned                   win_count;
   int unsigned                   seen_bytes;
   logic                          piece_active;

   split_result_type     step_results [$];
   split_result_type     expected_pieces [$];
   stim_row_type         offered_q [$];
   stim_row_type         directed_rows [$];

   int                   fail_count  = 0;
   int                   burst_left  = 0;
   int                   random_sent = 0;
   int                   hold_asks   = 0;
   int                   hold_taken  = 0;
   int                   hold_left   = 0;
   int                   stall_left  = 0;
   int                   stall_mode  = 0;
   int                   beat        = 0;

   delimiter_stream_splitter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned active_len(logic [dss_pkg::LEN_W-1:0] code);
      int unsigned len;
      len = code;
      if (len < 1) len = 1;
      if (len > dss_pkg::MAX_DELIM_LEN_DEF) len = dss_pkg::MAX_DELIM_LEN_DEF;
      return len;
   endfunction

   function automatic void clear_window();
      foreach (win_bytes[k]) win_bytes[k] = '0;
      win_count    = 0;
      seen_bytes   = 0;
      piece_active = 1'b0;
   endfunction

   function automatic void emit(dss_pkg::dss_kind_type kind, logic [dss_pkg::BYTE_W-1:0] b);
      step_results.push_back('{kind: kind, data: b, last: 1'b0});
   endfunction

   function automatic void split_step(logic [dss_pkg::BYTE_W-1:0] b, logic fin);
      int unsigned len;
      logic        hit;
      len = active_len(delim_len_code);
      step_results.delete();
      if (win_count >= len) win_count = 0;
      win_bytes[win_count] = b;
      win_count++;
      if (seen_bytes < len) seen_bytes++;
      if (win_count == len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (win_bytes[k] != delim_pattern[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            if (piece_active) emit(dss_pkg::KIND_PIECE_END, 8'h00);
            piece_active = 1'b0;
            win_count    = 0;
         end else begin
            emit(dss_pkg::KIND_DATA, win_bytes[0]);
            piece_active = 1'b1;
            for (int k = 1; k < len; k++) win_bytes[k-1] = win_bytes[k];
            win_count = len - 1;
         end
      end
      if (fin) begin
         if (seen_bytes >= len) begin
            for (int k = 0; k < win_count; k++) begin
               emit(dss_pkg::KIND_DATA, win_bytes[k]);
               piece_active = 1'b1;
            end
            if (piece_active) emit(dss_pkg::KIND_PIECE_END, 8'h00);
         end
         emit(dss_pkg::KIND_INPUT_END, 8'h00);
         clear_window();
      end
      if (step_results.size() > 0) step_results[$].last = 1'b1;
   endfunction

   function automatic stim_row_type byte_row(logic [dss_pkg::BYTE_W-1:0] b, logic fin);
      stim_row_type row;
      row      = '0;
      row.data = b;
      row.fin  = fin;
      return row;
   endfunction

   function automatic stim_row_type known_row(logic [dss_pkg::BYTE_W-1:0] b, logic fin,
                                              logic has_res, dss_pkg::dss_kind_type kind,
                                              logic [dss_pkg::BYTE_W-1:0] pb);
      stim_row_type row;
      row             = byte_row(b, fin);
      row.known       = 1'b1;
      row.known_count = has_res;
      row.known_res   = '{kind: kind, data: pb, last: 1'b1};
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [dss_pkg::CSR_IDX_W-1:0] idx,
                                            logic [dss_pkg::DELIM_W-1:0] value);
      stim_row_type row;
      row           = '0;
      row.is_csr    = 1'b1;
      row.csr_idx   = idx;
      row.csr_value = value;
      return row;
   endfunction

   task automatic send_byte(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.fin;
      offered_q.push_back(row);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_csr(input logic [dss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dss_pkg::DELIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drain all expected results, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_pieces.size() != 0 || offered_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_taken != hold_asks) begin
         hold_taken++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
         end
         stall_left--;
         beat++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 4) != 0);
            default: rsp_tready <= ((beat % 7) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      stim_row_type     row;
      split_result_type want;
      if (reset) begin
         delim_pattern  = '0;
         delim_len_code = 4'd1;
         clear_window();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == dss_pkg::CSR_DELIM_BYTES) begin
               delim_pattern = csr_data;
            end else if (csr_index == dss_pkg::CSR_DELIM_LENGTH) begin
               delim_len_code = csr_data[dss_pkg::LEN_W-1:0];
               clear_window();
            end
         end
         if (req_tvalid && req_tready) begin
            row = offered_q.pop_front();
            split_step(row.data, row.fin);
            if (row.known) begin
               if (row.known_count) expected_pieces.push_back(row.known_res);
            end else begin
               foreach (step_results[i]) expected_pieces.push_back(step_results[i]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pieces.size() == 0) begin
               $error("unexpected result: kind %0d byte %02h last %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_pieces.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("item_kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== want.data) begin
                  $error("piece_byte: expected %02h, actual %02h", want.data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [dss_pkg::DELIM_W-1:0] pattern;
      logic [dss_pkg::DELIM_W-1:0] len_value;
      logic [dss_pkg::LEN_W-1:0]   len_code;
      logic [dss_pkg::BYTE_W-1:0]  stream [$];
      int unsigned                 eff;
      int                          phase_no;
      int                          target;
      int                          pick;
      int                          cut;
      int                          streams;
      bit                          open_end;

      directed_rows = {
         known_row(8'h00, 1'b0, 1'b0, dss_pkg::KIND_DATA, 8'h00),
         known_row(8'hFF, 1'b0, 1'b1, dss_pkg::KIND_DATA, 8'hFF),
         known_row(8'h00, 1'b0, 1'b1, dss_pkg::KIND_PIECE_END, 8'h00),
         byte_row(8'h5A, 1'b1),
         csr_row(dss_pkg::CSR_DELIM_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
         csr_row(dss_pkg::CSR_DELIM_LENGTH, 64'd0),
         known_row(8'hFF, 1'b0, 1'b0, dss_pkg::KIND_DATA, 8'h00),
         known_row(8'hA5, 1'b0, 1'b1, dss_pkg::KIND_DATA, 8'hA5),
         byte_row(8'hFF, 1'b1),
         csr_row(dss_pkg::CSR_DELIM_BYTES, 64'h0000_0000_0000_2211),
         csr_row(dss_pkg::CSR_DELIM_LENGTH, 64'hFFFF_FFFF_FFFF_FFF2),
         known_row(8'h33, 1'b1, 1'b1, dss_pkg::KIND_INPUT_END, 8'h00),
         known_row(8'h11, 1'b0, 1'b0, dss_pkg::KIND_DATA, 8'h00),
         known_row(8'h22, 1'b0, 1'b0, dss_pkg::KIND_DATA, 8'h00),
         byte_row(8'h11, 1'b0),
         byte_row(8'h11, 1'b0),
         byte_row(8'h22, 1'b0),
         byte_row(8'h11, 1'b1),
         byte_row(8'h44, 1'b0),
         byte_row(8'h55, 1'b0),
         csr_row(dss_pkg::CSR_DELIM_LENGTH, 64'd15),
         csr_row(dss_pkg::CSR_DELIM_BYTES, 64'h0),
         known_row(8'h00, 1'b1, 1'b1, dss_pkg::KIND_INPUT_END, 8'h00),
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'h7F, 1'b1)
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_value);
         end else begin
            send_byte(directed_rows[i]);
         end
      end

      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_no++;
         if ($urandom_range(0, 4) == 0) begin
            pattern = {8{8'($urandom)}};
         end else begin
            pattern = {$urandom, $urandom};
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) len_code = 4'd1;
         else if (pick == 1) len_code = 4'd8;
         else if (pick == 2) len_code = 4'd0;
         else if (pick == 3) len_code = 4'($urandom_range(9, 15));
         else len_code = 4'($urandom_range(1, 8));
         len_value = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 0) len_value = '0;
         len_value[dss_pkg::LEN_W-1:0] = len_code;
         eff = active_len(len_code);

         settle();
         write_csr(dss_pkg::CSR_DELIM_BYTES, pattern);
         if (phase_no == 1 || $urandom_range(0, 3) != 0) begin
            write_csr(dss_pkg::CSR_DELIM_LENGTH, len_value);
         end else begin
            eff = active_len(delim_len_code);
         end

         streams = $urandom_range(1, 4);
         if (phase_no == 2) hold_asks++;
         for (int s = 0; s < streams; s++) begin
            stream.delete();
            if (phase_no == 2 && s == 0) target = PRESSURE_BYTES;
            else if ($urandom_range(0, 5) == 0) target = $urandom_range(1, eff);
            else target = $urandom_range(1, 24);
            while (stream.size() < target) begin
               pick = $urandom_range(0, 9);
               if (pick < 2) begin
                  for (int k = 0; k < eff; k++) stream.push_back(pattern[8*k +: 8]);
               end else if (pick == 2) begin
                  cut = $urandom_range(1, eff);
                  for (int k = 0; k < cut; k++) stream.push_back(pattern[8*k +: 8]);
               end else if (pick < 5) begin
                  cut = $urandom_range(0, eff - 1);
                  stream.push_back(pattern[8*cut +: 8]);
               end else begin
                  stream.push_back(8'($urandom));
               end
            end
            open_end = ($urandom_range(0, 9) == 0);
            foreach (stream[i]) begin
               send_byte(byte_row(stream[i], (i == stream.size() - 1) && !open_end));
               random_sent++;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
